// File: hw/rtl/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
package srsw_pkg;

	localparam int IDX_W       = 20;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 2;
	localparam int ACK_W       = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 2;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WINDOW_SLOTS  = 2'd0,
		REG_FIRST_SEQ     = 2'd1,
		REG_PACKET_TOTAL  = 2'd2,
		REG_TIMEOUT_TICKS = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SLIDE,
		ST_RESEND,
		ST_FILL,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic [5:0]       window_slots;
		logic [31:0]      first_seq;
		logic [IDX_W-1:0] packet_total;
		logic [IDX_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic             send_valid;
		logic [IDX_W-1:0] send_index;
		logic             is_resend;
		logic             last;
		logic             done_res;
	} res_t;

endpackage

// File: hw/rtl/srsw_alu.sv
// Shared subtract and compare unit.
module srsw_alu #(
	parameter int W = 32
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         lt
);

	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign lt   = full[W];

endmodule

// File: hw/rtl/srsw_core.sv
// Window state and event sequencer around the shared subtract unit.
module srsw_core #(
	parameter int MAX_WINDOW = 32,
	parameter int SEQ_BITS   = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  srsw_pkg::cfg_t            cfg,
	input  logic                      restart,
	input  logic [srsw_pkg::CFG_DATA_W-1:0] restart_seq,
	input  logic                      in_fire,
	input  logic                      in_kind,
	input  logic [srsw_pkg::ACK_W-1:0] in_ack,
	input  logic                      in_good,
	input  logic                      out_free,
	output logic                      in_ready,
	output logic                      push,
	output srsw_pkg::res_t            res
);

	import srsw_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int MAP_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int ALU_W = (SEQ_BITS > IDX_W) ? SEQ_BITS : IDX_W;

	st_t                  state_q, state_d;
	logic [SEQ_BITS-1:0]  base_q;
	logic [CNT_W-1:0]     infl_q;
	logic [MAX_WINDOW-1:0] acked_q;
	logic                 timer_on_q;
	logic [IDX_W-1:0]     tcnt_q;
	logic [IDX_W-1:0]     sent_q;
	logic [CNT_W-1:0]     off_q;
	logic                 kind_q;
	logic [SEQ_BITS-1:0]  ack_q;
	logic                 good_q;
	logic                 rs_q;
	logic                 pend_v_q;
	logic [IDX_W-1:0]     pend_idx_q;

	logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
	logic                 alu_lt;
	logic [CNT_W-1:0]     win_eff;
	logic [IDX_W-1:0]     cnt_new, tmo;
	logic                 off_ok, scan_act, unacked, can_fill, gen_ok, gen, adv;
	logic [IDX_W-1:0]     gen_idx;

	srsw_alu #(.W(ALU_W)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	always_comb begin
		if (cfg.window_slots == 6'd0) begin
			win_eff = CNT_W'(1);
		end else if (7'(cfg.window_slots) > 7'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(cfg.window_slots);
		end
	end

	assign cnt_new  = (tcnt_q == IDX_MAX) ? tcnt_q : tcnt_q + IDX_W'(1);
	assign tmo      = (cfg.timeout_ticks == '0) ? IDX_W'(1) : cfg.timeout_ticks;
	assign off_ok   = alu_diff[SEQ_BITS-1:0] < SEQ_BITS'(infl_q);
	assign scan_act = off_q < infl_q;
	assign unacked  = !acked_q[off_q[MAP_W-1:0]];
	assign can_fill = alu_lt && (infl_q < win_eff);
	assign gen_ok   = !pend_v_q || out_free;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (kind_q == KIND_TICK) begin
					state_d = (timer_on_q && !alu_lt) ? ST_RESEND : ST_FILL;
				end else begin
					state_d = (good_q && off_ok) ? ST_SLIDE : ST_FILL;
				end
			end
			ST_SLIDE: begin
				if (!(infl_q != '0 && acked_q[0])) state_d = ST_FILL;
			end
			ST_RESEND: begin
				if (!scan_act) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (!can_fill) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		gen     = 1'b0;
		adv     = 1'b0;
		gen_idx = '0;
		push    = 1'b0;
		res     = '0;
		unique case (state_q)
			ST_EVAL: begin
				if (kind_q == KIND_TICK) begin
					alu_a = ALU_W'(cnt_new);
					alu_b = ALU_W'(tmo);
				end else begin
					alu_a = ALU_W'(ack_q);
					alu_b = ALU_W'(base_q);
				end
			end
			ST_RESEND: begin
				alu_a   = ALU_W'(sent_q);
				alu_b   = ALU_W'(infl_q - off_q);
				gen_idx = alu_diff[IDX_W-1:0];
				gen     = scan_act && unacked && gen_ok;
				adv     = scan_act && (!unacked || gen_ok);
			end
			ST_FILL: begin
				alu_a   = ALU_W'(sent_q);
				alu_b   = ALU_W'(cfg.packet_total);
				gen_idx = sent_q;
				gen     = can_fill && gen_ok;
			end
			ST_FINISH: begin
				alu_a = ALU_W'(sent_q);
				alu_b = ALU_W'(cfg.packet_total);
			end
			ST_IDLE, ST_SLIDE: begin
			end
			default: begin
			end
		endcase

		if (gen && pend_v_q) begin
			push           = 1'b1;
			res.send_valid = 1'b1;
			res.send_index = pend_idx_q;
			res.is_resend  = rs_q;
		end else if (state_q == ST_FINISH && out_free) begin
			push     = 1'b1;
			res.last = 1'b1;
			if (pend_v_q) begin
				res.send_valid = 1'b1;
				res.send_index = pend_idx_q;
				res.is_resend  = rs_q;
			end else begin
				res.done_res = !alu_lt && (infl_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			infl_q     <= '0;
			acked_q    <= '0;
			timer_on_q <= 1'b0;
			tcnt_q     <= '0;
			sent_q     <= '0;
			off_q      <= '0;
			rs_q       <= 1'b0;
			pend_v_q   <= 1'b0;
		end else if (restart) begin
			base_q     <= restart_seq[SEQ_BITS-1:0];
			infl_q     <= '0;
			acked_q    <= '0;
			timer_on_q <= 1'b0;
			tcnt_q     <= '0;
			sent_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rs_q  <= 1'b0;
						off_q <= '0;
					end
				end
				ST_EVAL: begin
					if (kind_q == KIND_TICK) begin
						if (timer_on_q) begin
							tcnt_q <= alu_lt ? cnt_new : '0;
							if (!alu_lt) rs_q <= 1'b1;
						end
					end else if (good_q && off_ok) begin
						acked_q[alu_diff[MAP_W-1:0]] <= 1'b1;
						tcnt_q                       <= '0;
					end
				end
				ST_SLIDE: begin
					if (infl_q != '0 && acked_q[0]) begin
						acked_q <= acked_q >> 1;
						base_q  <= base_q + SEQ_BITS'(1);
						infl_q  <= infl_q - CNT_W'(1);
					end else begin
						timer_on_q <= (infl_q != '0);
					end
				end
				ST_RESEND: begin
					if (adv) off_q <= off_q + CNT_W'(1);
				end
				ST_FILL: begin
					if (gen) begin
						acked_q[infl_q[MAP_W-1:0]] <= 1'b0;
						if (infl_q == '0) begin
							timer_on_q <= 1'b1;
							tcnt_q     <= '0;
						end
						sent_q <= sent_q + IDX_W'(1);
						infl_q <= infl_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) pend_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (gen) pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && state_q == ST_IDLE) begin
			kind_q <= in_kind;
			ack_q  <= in_ack[SEQ_BITS-1:0];
			good_q <= in_good;
		end
		if (gen) pend_idx_q <= gen_idx;
	end

endmodule

// File: hw/rtl/selective_repeat_sender_window.sv
// Selective-repeat sender window: top level with registers and output stage.
// Steps: a tick is evaluated, then fills; a good in-window ack is evaluated, slides the window
// and fills; a timeout is evaluated, scans for resends and fills; every item then finishes.
// Flow: one item at a time, the next taken in the cycle after the last result; results leave
// at most one per cycle when output is free, from the scan and fill steps via a hold register.
// Reset: asynchronous active-low; registers to defaults, window empty, timer stopped.
module selective_repeat_sender_window #(
	parameter int MAX_WINDOW = 32,
	parameter int SEQ_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [srsw_pkg::IN_TDATA_W-1:0]      s_tdata,  // ack_seq[31:0], ack_good, pad
	input  logic                                 s_tuser,  // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [srsw_pkg::OUT_TDATA_W-1:0]     m_tdata,  // send_index[19:0], done_res, pad
	output logic [srsw_pkg::OUT_TUSER_W-1:0]     m_tuser,  // send_valid, is_resend
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srsw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [srsw_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import srsw_pkg::*;

	cfg_t cfg_q;
	res_t res, out_q;
	logic out_valid_q;
	logic cfg_fire, in_fire, out_free, push, in_ready;
	logic [CFG_DATA_W-1:0] restart_seq;

	assign cfg_ready   = 1'b1;
	assign cfg_fire    = cfg_valid && cfg_ready;
	assign s_tready    = in_ready;
	assign in_fire     = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;
	assign restart_seq = (cfg_addr == REG_FIRST_SEQ) ? cfg_data : cfg_q.first_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_slots  <= 6'd32;
			cfg_q.first_seq     <= '0;
			cfg_q.packet_total  <= '0;
			cfg_q.timeout_ticks <= IDX_W'(100);
		end else if (cfg_fire) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_WINDOW_SLOTS:  cfg_q.window_slots  <= cfg_data[5:0];
				REG_FIRST_SEQ:     cfg_q.first_seq     <= cfg_data;
				REG_PACKET_TOTAL:  cfg_q.packet_total  <= cfg_data[IDX_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	srsw_core #(
		.MAX_WINDOW (MAX_WINDOW),
		.SEQ_BITS   (SEQ_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.restart     (cfg_fire),
		.restart_seq (restart_seq),
		.in_fire     (in_fire),
		.in_kind     (s_tuser),
		.in_ack      (s_tdata[ACK_W-1:0]),
		.in_good     (s_tdata[ACK_W]),
		.out_free    (out_free),
		.in_ready    (in_ready),
		.push        (push),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.done_res, out_q.send_index};
	assign m_tuser  = {out_q.is_resend, out_q.send_valid};
	assign m_tlast  = out_q.last;

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input accepted again before the item finished");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("status result not marked last");

	a_done_without_send: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[IDX_W]) |-> (!m_tuser[0] && !m_tuser[1]))
		else $error("done raised on a send result");
`endif

endmodule
